/* src/bpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 packet framer package
// Shared types, codes, constants and the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package bpf_pkg;

   localparam int MAX_RESULTS = 10;
   localparam int COUNT_W     = 4;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   localparam logic [1:0] CSR_HEADER_CHARS  = 2'd0;
   localparam logic [1:0] CSR_HEADER_LENGTH = 2'd1;
   localparam logic [1:0] CSR_LINE_LENGTH   = 2'd2;
   localparam logic [1:0] CSR_MAX_LENGTH    = 2'd3;

   localparam logic [7:0]  CHAR_NEWLINE      = 8'h0a;
   localparam logic [7:0]  CHAR_PAD          = 8'h3d;
   localparam logic [7:0]  CHAR_ERROR        = 8'h00;
   localparam logic [3:0]  HEADER_MAX        = 4'd8;
   localparam logic [7:0]  LINE_LENGTH_RESET = 8'd76;
   localparam logic [15:0] MAX_LENGTH_RESET  = 16'd4096;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  payload_byte;
      logic [15:0] packet_length;
   } item_type;

   typedef struct packed {
      logic [63:0] header_chars;
      logic [3:0]  header_length;
      logic [7:0]  line_length;
      logic [15:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [COUNT_W-1:0]          count;
      logic                        err;
   } result_list_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* src/bpf_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 packet framer: framing logic
// Holds the packet state and turns one transaction into its list of characters.
// ----------------------------------------------------------------------------
module bpf_framer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire bpf_pkg::item_type        item,
   input  wire bpf_pkg::cfg_type         cfg,
   output bpf_pkg::result_list_type      results
);

   typedef struct packed {
      logic [15:0] group_bytes;
      logic [1:0]  group_count;
      logic [15:0] running_sum;
      logic [7:0]  line_count;
      logic        packet_open;
   } state_type;

   typedef struct packed {
      state_type                st;
      bpf_pkg::result_list_type res;
   } frame_type;

   state_type state_ff;
   frame_type frame_in;

   function automatic bpf_pkg::result_list_type push(input bpf_pkg::result_list_type r,
                                                     input logic [7:0] ch);
      bpf_pkg::result_list_type o;
      o = r;
      for (int k = 0; k < bpf_pkg::MAX_RESULTS; k++) begin
         if (bpf_pkg::COUNT_W'(k) == r.count) begin
            o.chars[k] = ch;
         end
      end
      o.count = r.count + 1'b1;
      return o;
   endfunction

   function automatic frame_type group_push(input frame_type f, input logic [7:0] b,
                                            input logic [7:0] ll);
      frame_type   r;
      logic [23:0] word;
      logic [8:0]  lsum;
      r = f;
      word = {f.st.group_bytes, b};
      lsum = {1'b0, f.st.line_count} + 9'd4;
      if (f.st.group_count >= 2'd2) begin
         r.res = push(r.res, bpf_pkg::b64_char(word[23:18]));
         r.res = push(r.res, bpf_pkg::b64_char(word[17:12]));
         r.res = push(r.res, bpf_pkg::b64_char(word[11:6]));
         r.res = push(r.res, bpf_pkg::b64_char(word[5:0]));
         r.st.group_bytes = '0;
         r.st.group_count = '0;
         r.st.line_count = lsum[8] ? 8'hff : lsum[7:0];
         if (r.st.line_count >= ll) begin
            r.res = push(r.res, bpf_pkg::CHAR_NEWLINE);
            r.st.line_count = '0;
         end
      end else begin
         r.st.group_bytes = {f.st.group_bytes[7:0], b};
         r.st.group_count = f.st.group_count + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      logic [3:0] n;
      logic [15:0] gb;
      frame_in.st = state_ff;
      frame_in.res = '0;
      gb = '0;
      n = (cfg.header_length > bpf_pkg::HEADER_MAX) ? bpf_pkg::HEADER_MAX : cfg.header_length;
      case (item.action)
         bpf_pkg::ACT_START: begin
            if (item.packet_length > cfg.max_length) begin
               frame_in.st.packet_open = 1'b0;
               frame_in.res = push(frame_in.res, bpf_pkg::CHAR_ERROR);
               frame_in.res.err = 1'b1;
            end else begin
               for (int i = 0; i < 8; i++) begin
                  frame_in.res.chars[i] = cfg.header_chars[63 - 8 * i -: 8];
               end
               frame_in.res.count = n;
               frame_in.st.group_bytes = item.packet_length;
               frame_in.st.group_count = 2'd2;
               frame_in.st.running_sum = '0;
               frame_in.st.line_count = {4'b0000, n};
               frame_in.st.packet_open = 1'b1;
            end
         end
         bpf_pkg::ACT_BYTE: begin
            if (state_ff.packet_open) begin
               frame_in.st.running_sum = state_ff.running_sum + {8'h00, item.payload_byte};
               frame_in = group_push(frame_in, item.payload_byte, cfg.line_length);
            end
         end
         bpf_pkg::ACT_END: begin
            if (state_ff.packet_open) begin
               frame_in = group_push(frame_in, state_ff.running_sum[15:8], cfg.line_length);
               frame_in = group_push(frame_in, state_ff.running_sum[7:0], cfg.line_length);
               gb = frame_in.st.group_bytes;
               if (frame_in.st.group_count == 2'd1) begin
                  frame_in.res = push(frame_in.res, bpf_pkg::b64_char(gb[7:2]));
                  frame_in.res = push(frame_in.res, bpf_pkg::b64_char({gb[1:0], 4'b0000}));
                  frame_in.res = push(frame_in.res, bpf_pkg::CHAR_PAD);
                  frame_in.res = push(frame_in.res, bpf_pkg::CHAR_PAD);
               end else if (frame_in.st.group_count == 2'd2) begin
                  frame_in.res = push(frame_in.res, bpf_pkg::b64_char(gb[15:10]));
                  frame_in.res = push(frame_in.res, bpf_pkg::b64_char(gb[9:4]));
                  frame_in.res = push(frame_in.res, bpf_pkg::b64_char({gb[3:0], 2'b00}));
                  frame_in.res = push(frame_in.res, bpf_pkg::CHAR_PAD);
               end
               frame_in.res = push(frame_in.res, bpf_pkg::CHAR_NEWLINE);
               frame_in.st.group_bytes = '0;
               frame_in.st.group_count = '0;
               frame_in.st.line_count = '0;
               frame_in.st.packet_open = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= frame_in.st;
      end
   end

   assign results = frame_in.res;

endmodule
`default_nettype wire

/* src/bpf_char_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 packet framer: character queue
// Result register that holds one transaction's characters and shifts them out.
// ----------------------------------------------------------------------------
module bpf_char_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire bpf_pkg::result_list_type results,
   output logic                          free,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_run_last,
   output logic                          rsp_too_long
);

   logic [bpf_pkg::MAX_RESULTS-1:0][7:0] chars_ff;
   logic [bpf_pkg::MAX_RESULTS-1:0][7:0] chars_in;
   logic [bpf_pkg::COUNT_W-1:0]          remain_ff;
   logic [bpf_pkg::COUNT_W-1:0]          remain_in;
   logic                                 err_ff;
   logic                                 err_in;
   logic                                 take;

   assign rsp_valid    = (remain_ff != '0);
   assign take         = rsp_valid && !rsp_stall;
   assign free         = (remain_ff == '0) || ((remain_ff == bpf_pkg::COUNT_W'(1)) && take);
   assign rsp_out_char = chars_ff[0];
   assign rsp_run_last = (remain_ff == bpf_pkg::COUNT_W'(1));
   assign rsp_too_long = err_ff;

   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      err_in    = err_ff;
      if (load) begin
         chars_in  = results.chars;
         remain_in = results.count;
         err_in    = results.err;
      end else if (take) begin
         for (int k = 0; k < bpf_pkg::MAX_RESULTS - 1; k++) begin
            chars_in[k] = chars_ff[k + 1];
         end
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      err_ff   <= err_in;
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

endmodule
`default_nettype wire

/* src/base64_packet_framer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 packet framer core
// Frames packets as base64 text lines with header, length and checksum.
// ----------------------------------------------------------------------------
// An accepted transaction is held in the hold register and moves through the
// framer into the result queue once the queue is free; its first character is
// then offered from the queue. Throughput: one character per cycle from the
// result queue while rsp_stall is low; the single output port sets that rate.
// Reset is synchronous and clears the pipeline, the packet state and the
// registers to their defaults.
module base64_packet_framer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic [15:0] req_packet_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_too_long
);

   bpf_pkg::cfg_type         cfg_ff;
   bpf_pkg::item_type        hold_item_ff;
   logic                     hold_valid_ff;
   logic                     hold_valid_in;
   logic                     queue_free;
   logic                     move;
   logic                     accept;
   bpf_pkg::result_list_type results;

   assign move      = hold_valid_ff && queue_free;
   assign req_stall = hold_valid_ff && !queue_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (move) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff.action        <= req_action;
         hold_item_ff.payload_byte  <= req_payload_byte;
         hold_item_ff.packet_length <= req_packet_length;
      end
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_chars  <= '0;
         cfg_ff.header_length <= '0;
         cfg_ff.line_length   <= bpf_pkg::LINE_LENGTH_RESET;
         cfg_ff.max_length    <= bpf_pkg::MAX_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bpf_pkg::CSR_HEADER_CHARS:  cfg_ff.header_chars  <= csr_data;
            bpf_pkg::CSR_HEADER_LENGTH: cfg_ff.header_length <= csr_data[3:0];
            bpf_pkg::CSR_LINE_LENGTH:   cfg_ff.line_length   <= csr_data[7:0];
            bpf_pkg::CSR_MAX_LENGTH:    cfg_ff.max_length    <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   bpf_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (move),
      .item    (hold_item_ff),
      .cfg     (cfg_ff),
      .results (results)
   );

   bpf_char_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (move),
      .results      (results),
      .free         (queue_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .rsp_too_long (rsp_too_long)
   );

`ifndef ASSERT_OFF
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_run_last && (rsp_out_char == bpf_pkg::CHAR_ERROR))
      else $error("rejected start did not give a single error transaction");

   a_reject_reported: assert property (@(posedge clock) disable iff (reset)
      move && (hold_item_ff.action == bpf_pkg::ACT_START)
      && (hold_item_ff.packet_length > cfg_ff.max_length) |=> rsp_valid && rsp_too_long)
      else $error("over-length start did not report an error");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_run_last && !move |=> !rsp_valid)
      else $error("result queue kept a character after the last one was taken");
`endif

endmodule
`default_nettype wire
